[src/hisc_pkg.sv]
package hisc_pkg;

  localparam int BIN_W   = 16;
  localparam int SCORE_W = 17;
  localparam int USED_W  = 13;

  typedef struct packed {
    logic [BIN_W-1:0] bin_count_a;
    logic [BIN_W-1:0] bin_count_b;
    logic             last_bin;
  } in_payload_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               no_bins;
    logic [USED_W-1:0]  used_bins;
  } out_payload_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TERM,
    S_ACC,
    S_FINISH,
    S_MEAN,
    S_EMIT
  } state_t;

endpackage

[src/histogram_intersection_score.sv]
// A zero bin pair that is not the last is only accepted; a counted pair is accepted,
// runs FRAC_BITS+1 divider steps and is accumulated. A last bin adds a load,
// FRAC_BITS+1 divider steps and the output write, skipping the division when no pair
// was counted; the write waits for a free output register, and the score is valid the
// cycle after the write. Throughput: one transaction at a time, not ready while busy.
// Reset (rst_n low, synchronous) clears the sequencer, sum, count and output valid.
module histogram_intersection_score
  import hisc_pkg::*;
#(
  parameter int COUNT_BITS = 16,
  parameter int MAX_BINS   = 4096,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  in_payload_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output out_payload_t out_data
);

  // Bits of each count that take part in the arithmetic
  localparam int CW     = (COUNT_BITS < BIN_W) ? COUNT_BITS : BIN_W;
  // Quotient bits: every quotient here is at most 2^FRAC_BITS
  localparam int Q      = FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int SUM_W  = FRAC_BITS + CNT_W;
  localparam int DIV_W  = (CW + 1 > CNT_W) ? CW + 1 : CNT_W;
  localparam int STEP_W = $clog2(Q);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(Q - 1);
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_BINS);

  state_t state_r, state_nxt;

  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  count_r;
  logic              last_r;

  // Shared divider: partial remainder, quotient/dividend shift register, divisor
  logic [DIV_W-1:0]  rem_r;
  logic [Q-1:0]      quo_r;
  logic [DIV_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;

  logic              out_valid_r;
  out_payload_t      out_data_r;

  logic [CW-1:0]     a_w, b_w, lo_w;
  logic [CW:0]       total_w;
  logic              pair_used_w;
  logic [DIV_W:0]    trial_w, diff_w;
  logic              fits_w;
  logic              slot_free_w;

  logic load_pair, load_mean, clear_quo, div_step, acc_en, emit;

  // ---------------------------------------------------------------------------
  // Input decode: mask the counts and decide whether the pair is counted.
  // The pair term is (2*lo << FRAC_BITS) / (a+b); its top part is just lo and
  // its low Q dividend bits are zero, so the divider loads lo as remainder.
  // ---------------------------------------------------------------------------
  assign a_w         = in_data.bin_count_a[CW-1:0];
  assign b_w         = in_data.bin_count_b[CW-1:0];
  assign lo_w        = (a_w <= b_w) ? a_w : b_w;
  assign total_w     = {1'b0, a_w} + {1'b0, b_w};
  assign pair_used_w = ((a_w != '0) || (b_w != '0)) && (count_r < MAX_CNT);

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial_w = {rem_r, quo_r[Q-1]};
  assign fits_w  = trial_w >= {1'b0, div_r};
  assign diff_w  = trial_w - {1'b0, div_r};

  // The output register may take a new transaction when empty or being drained
  assign slot_free_w = !out_valid_r || out_ready;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (pair_used_w) begin
            state_nxt = S_TERM;
          end else if (in_data.last_bin) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_TERM: begin
        if (step_r == LAST_STEP) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        state_nxt = last_r ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        state_nxt = (count_r == '0) ? S_EMIT : S_MEAN;
      end
      S_MEAN: begin
        if (step_r == LAST_STEP) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free_w) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    load_pair = 1'b0;
    load_mean = 1'b0;
    clear_quo = 1'b0;
    div_step  = 1'b0;
    acc_en    = 1'b0;
    emit      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        load_pair = in_valid && pair_used_w;
      end
      S_TERM: begin
        div_step = 1'b1;
      end
      S_ACC: begin
        acc_en = 1'b1;
      end
      S_FINISH: begin
        // Empty comparison: skip the division and report a zero score
        load_mean = (count_r != '0);
        clear_quo = (count_r == '0);
      end
      S_MEAN: begin
        div_step = 1'b1;
      end
      S_EMIT: begin
        emit = slot_free_w;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc_en) begin
        sum_r   <= sum_r + SUM_W'(quo_r);
        count_r <= count_r + CNT_W'(1);
      end else if (emit) begin
        // Clear for the next comparison once the result is taken over
        sum_r   <= '0;
        count_r <= '0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers: divider and output payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      last_r <= in_data.last_bin;
    end
    if (load_pair) begin
      rem_r  <= DIV_W'(lo_w);
      quo_r  <= '0;
      div_r  <= DIV_W'(total_w);
      step_r <= '0;
    end else if (load_mean) begin
      // Mean = sum / count; the high part is already below count
      rem_r  <= DIV_W'(sum_r >> Q);
      quo_r  <= sum_r[Q-1:0];
      div_r  <= DIV_W'(count_r);
      step_r <= '0;
    end else if (clear_quo) begin
      quo_r <= '0;
    end else if (div_step) begin
      rem_r  <= fits_w ? diff_w[DIV_W-1:0] : trial_w[DIV_W-1:0];
      quo_r  <= {quo_r[Q-2:0], fits_w};
      step_r <= step_r + STEP_W'(1);
    end
    if (emit) begin
      out_data_r.score     <= SCORE_W'(quo_r);
      out_data_r.no_bins   <= (count_r == '0);
      out_data_r.used_bins <= USED_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("used count beyond MAX_BINS");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TERM || state_r == S_MEAN) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("output transaction raised outside emit");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.no_bins) |->
      (out_data_r.score == '0 && out_data_r.used_bins == '0))
    else $error("empty comparison with nonzero score or count");

endmodule

[tb/histogram_intersection_score_tb.sv]
module histogram_intersection_score_tb
  import hisc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Match the block's default build; the predictor relies on these.
  localparam int COUNT_BITS = 16;
  localparam int MAX_BINS   = 4096;
  localparam int FRAC_BITS  = 16;

  // Cycles to let pass after the last score.
  localparam int TAIL_CYCLES = FRAC_BITS + 8;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  in_payload_t  in_data;
  logic         out_valid;
  logic         out_ready;
  out_payload_t out_data;

  histogram_intersection_score #(
    .COUNT_BITS(COUNT_BITS),
    .MAX_BINS  (MAX_BINS),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Predictor state: running sum of intersection terms and number of counted pairs.
  longint unsigned running_term_sum;
  int unsigned     counted_pairs;
  out_payload_t    pending_scores[$];

  // Idling controls. Set after a rising edge; read and hold_left decremented at a falling edge.
  int gap_pct;
  int stall_pct;
  int hold_left;

  int mismatches;
  int bins_sent;
  int scores_checked;
  int empty_scores;
  int saturated_scores;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // One term of the intersection, 2*min/(a+b) with FRAC_BITS fraction bits, truncated.
  function automatic longint unsigned intersection_term(input logic [BIN_W-1:0] a,
                                                        input logic [BIN_W-1:0] b);
    longint unsigned lo;
    longint unsigned total;
    lo    = (a <= b) ? longint'(a) : longint'(b);
    total = longint'(a) + longint'(b);
    if (total == 0) return 0;
    return ((lo * 2) << FRAC_BITS) / total;
  endfunction

  // Fold one accepted bin pair into the predictor; queue the score on the last bin.
  function automatic void fold_bin_pair(input in_payload_t pair);
    logic [COUNT_BITS-1:0] a;
    logic [COUNT_BITS-1:0] b;
    out_payload_t          score_item;
    a = pair.bin_count_a[COUNT_BITS-1:0];
    b = pair.bin_count_b[COUNT_BITS-1:0];
    if ((a != 0 || b != 0) && counted_pairs < MAX_BINS) begin
      running_term_sum += intersection_term(a, b);
      counted_pairs++;
    end
    if (!pair.last_bin) return;
    if (counted_pairs == 0) begin
      score_item.score     = '0;
      score_item.no_bins   = 1'b1;
      score_item.used_bins = '0;
    end else begin
      score_item.score     = SCORE_W'(running_term_sum / counted_pairs);
      score_item.no_bins   = 1'b0;
      score_item.used_bins = USED_W'(counted_pairs);
    end
    pending_scores.push_back(score_item);
    running_term_sum = 0;
    counted_pairs    = 0;
  endfunction

  // Offer one bin pair. Entered and left at a falling edge; valid stays high on
  // return so a back-to-back transaction does not drop it for a step.
  task automatic offer_bin_pair(input logic [BIN_W-1:0] a, input logic [BIN_W-1:0] b,
                                input logic last);
    in_payload_t pair;
    pair.bin_count_a = a;
    pair.bin_count_b = b;
    pair.last_bin    = last;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pair;
    do @(posedge clk); while (!in_ready);
    fold_bin_pair(pair);
    bins_sent++;
    @(negedge clk);
  endtask

  // Lower valid and hold the sender until every queued score has come back.
  task automatic wait_for_scores();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_scores.size() != 0);
  endtask

  // Change idling between phases. Drain first so no transaction slips through
  // while the sender sits at the rising edge.
  task automatic set_idling(input int gap, input int stall, input int hold);
    wait_for_scores();
    @(posedge clk);
    gap_pct   = gap;
    stall_pct = stall;
    hold_left = hold;
    @(negedge clk);
  endtask

  function automatic logic [BIN_W-1:0] random_count();
    case ($urandom_range(7))
      0:       return '0;
      1:       return BIN_W'($urandom_range(1, 15));
      2:       return '1;
      default: return BIN_W'($urandom());
    endcase
  endfunction

  // Mostly short comparisons so scores come often; now and then a full 59-bin
  // uniform LBP histogram or something in between.
  function automatic int comparison_length();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 12);
    if (r < 90) return 59;
    return $urandom_range(13, 58);
  endfunction

  // Extremes of the counts, all-zero comparisons, equal counts, a zero last bin.
  task automatic test_directed_extremes();
    set_idling(0, 0, 0);
    offer_bin_pair(16'd0, 16'd0, 1'b1);             // empty comparison on its own
    offer_bin_pair(16'hFFFF, 16'hFFFF, 1'b0);       // equal counts give exactly 1.0
    offer_bin_pair(16'd1, 16'hFFFF, 1'b0);
    offer_bin_pair(16'hFFFF, 16'd0, 1'b0);
    offer_bin_pair(16'd0, 16'd1, 1'b0);
    offer_bin_pair(16'd0, 16'd0, 1'b0);             // skipped mid-comparison
    offer_bin_pair(16'hFFFF, 16'hFFFE, 1'b1);
    offer_bin_pair(16'd0, 16'd0, 1'b0);             // several zero pairs, still empty
    offer_bin_pair(16'd0, 16'd0, 1'b0);
    offer_bin_pair(16'd0, 16'd0, 1'b1);
    offer_bin_pair(16'd1, 16'd1, 1'b1);             // smallest equal pair
    offer_bin_pair(16'h5555, 16'hAAAA, 1'b0);       // walk every bit both ways
    offer_bin_pair(16'hAAAA, 16'h5555, 1'b1);
    offer_bin_pair(16'd3, 16'd0, 1'b0);             // last bin itself is a zero pair
    offer_bin_pair(16'd0, 16'd0, 1'b1);
    offer_bin_pair(16'd1, 16'd2, 1'b1);             // truncated two thirds
    offer_bin_pair(16'h8000, 16'h7FFF, 1'b0);
    offer_bin_pair(16'd0, 16'hFFFF, 1'b1);
    wait_for_scores();
  endtask

  // MAX_BINS+8 pairs, a zero pair in every 512, the last one too, so no last bin; MAX_BINS-1 are counted.
  task automatic test_bin_saturation();
    int total;
    set_idling(0, 0, 0);
    total = MAX_BINS + 8;
    for (int i = 0; i < total; i++) begin
      if (i % 512 == 7)
        offer_bin_pair(16'd0, 16'd0, 1'b0);
      else
        offer_bin_pair(BIN_W'($urandom_range(1, 65535)), random_count(), i == total - 1);
    end
    wait_for_scores();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  // short comparisons, so the pending score backs the block up into its input.
  task automatic test_output_backpressure();
    set_idling(0, 0, 400);
    for (int c = 0; c < 6; c++) begin
      for (int i = 0; i < 3; i++)
        offer_bin_pair(random_count(), random_count(), i == 2);
    end
    wait_for_scores();
  endtask

  // Well-formed comparisons with random content, with stray empty comparisons
  // thrown in, until about n_bins transactions have gone in.
  task automatic test_random_comparisons(input int n_bins, input int gap, input int stall);
    int sent;
    int len;
    logic [BIN_W-1:0] a;
    logic [BIN_W-1:0] b;
    int r;
    set_idling(gap, stall, 0);
    sent = 0;
    while (sent < n_bins) begin
      if ($urandom_range(99) < 5) begin
        offer_bin_pair(16'd0, 16'd0, 1'b1);
        sent++;
      end else begin
        len = comparison_length();
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(99);
          if (r < 12) begin
            a = '0;
            b = '0;
          end else if (r < 25) begin
            a = random_count();
            b = a;
          end else begin
            a = random_count();
            b = random_count();
          end
          offer_bin_pair(a, b, i == len - 1);
        end
        sent += len;
      end
      // Now and then pause the sender until the block has fully drained.
      if ($urandom_range(99) < 4) wait_for_scores();
    end
    wait_for_scores();
  endtask

  // Receiver: stall at random, or hold off for a counted stretch when asked.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Score checker: compare each accepted transaction with the oldest expectation.
  always @(posedge clk) begin
    out_payload_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch($sformatf("score %0d arrived with nothing expected",
                                  out_data.score));
      end else begin
        want = pending_scores.pop_front();
        scores_checked++;
        if (want.no_bins) empty_scores++;
        if (want.used_bins == MAX_BINS) saturated_scores++;
        if (out_data.score !== want.score)
          report_mismatch($sformatf("score %0d, expected %0d",
                                    out_data.score, want.score));
        if (out_data.no_bins !== want.no_bins)
          report_mismatch($sformatf("no_bins %0b, expected %0b",
                                    out_data.no_bins, want.no_bins));
        if (out_data.used_bins !== want.used_bins)
          report_mismatch($sformatf("used_bins %0d, expected %0d",
                                    out_data.used_bins, want.used_bins));
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    gap_pct          = 0;
    stall_pct        = 0;
    hold_left        = 0;
    running_term_sum = 0;
    counted_pairs    = 0;
    mismatches       = 0;
    bins_sent        = 0;
    scores_checked   = 0;
    empty_scores     = 0;
    saturated_scores = 0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_extremes();
    test_output_backpressure();
    test_bin_saturation();
    test_random_comparisons(375, 0, 0);
    test_random_comparisons(375, 79, 0);
    test_random_comparisons(375, 0, 79);
    test_random_comparisons(375, 37, 37);

    // Drain, then give any stray result time to show up.
    wait_for_scores();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d bin pairs and %0d scores (%0d empty, %0d saturated at %0d bins)",
             bins_sent, scores_checked, empty_scores, saturated_scores, MAX_BINS);
    $display("idling: none, sender gaps, receiver stalls, both, plus a %0d-cycle hold-off",
             400);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
